/* rtl/core/asob_pkg.sv */
// ----------------------------------------------------------------------------
// asob_pkg: shared types and constants of the sine oscillator bank
// Holds the bank geometry, the request type, and the quarter-wave sine table
// that is built once at elaboration.
// ----------------------------------------------------------------------------
package asob_pkg;

  localparam int PARTIALS        = 512;
  localparam int IDX_W           = 9;
  localparam int CNT_W           = 10;
  localparam int PHASE_BITS      = 24;
  localparam int SINE_TABLE_BITS = 10;
  localparam int AMP_W           = 16;
  localparam int BASE_W          = 32;
  localparam int ACC_W           = 64;
  localparam int QUEUE_DEPTH     = 2;   // power of two, at least 2
  localparam int RAM_W           = 2 * PHASE_BITS + AMP_W;
  localparam int QLEN            = 1 << (SINE_TABLE_BITS - 2);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        partial_index;
    logic [PHASE_BITS-1:0]   phase_increment;
    logic signed [AMP_W-1:0] amplitude;
    logic [PHASE_BITS-1:0]   phase_offset;
    logic signed [BASE_W-1:0] base_sample;
  } req_t;

  localparam int REQ_W = $bits(req_t);

  // sine of k/QLEN quarter turns as Q15, odd polynomial to the x^11 term
  function automatic logic [15:0] quarter_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x = (64'd1686629713 * 64'(k)) >> (SINE_TABLE_BITS - 2);
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd110);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd72);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd42);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd20);
    t = (64'd1 << 30) - (((x2 * t) >> 30) / 64'd6);
    s = (x * t) >> 30;
    v = (s + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return 16'(v);
  endfunction

  function automatic logic [QLEN*16-1:0] quarter_rom_build();
    logic [QLEN*16-1:0] rom;
    rom = '0;
    for (int unsigned k = 0; k < QLEN; k++) rom[k*16 +: 16] = quarter_sine(k);
    return rom;
  endfunction

  // first quarter, entries 0 .. QLEN-1; the quarter-turn point is kept apart
  localparam logic [QLEN*16-1:0] QUARTER_ROM = quarter_rom_build();
  localparam logic [15:0]        SINE_PEAK   = quarter_sine(QLEN);

endpackage

/* rtl/core/asob_ram.sv */
// ----------------------------------------------------------------------------
// asob_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module asob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/asob_front.sv */
// ----------------------------------------------------------------------------
// asob_front: request intake and queue
// Accepts requests into a short FIFO that the engine drains.
// ----------------------------------------------------------------------------
module asob_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  asob_pkg::req_t        in_req,
  output logic                  q_valid,
  input  logic                  q_pop,
  output asob_pkg::req_t        q_req
);

  localparam int PW = $clog2(asob_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(asob_pkg::QUEUE_DEPTH + 1);

  asob_pkg::req_t slot_r [asob_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;

  assign in_tready = (cnt_r != CW'(asob_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_req     = slot_r[rd_ptr_r];

  // pointers wrap on their own width
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push);
    rd_ptr_nxt = rd_ptr_r + PW'(q_pop);
    cnt_nxt    = cnt_r + CW'(push) - CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= in_req;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* rtl/core/asob_engine.sv */
// ----------------------------------------------------------------------------
// asob_engine: partial sweep engine
// Executes loads and ticks; a tick walks the partial memories one per cycle.
// ----------------------------------------------------------------------------
module asob_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [asob_pkg::CNT_W-1:0]        partials_in_use,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  asob_pkg::req_t                    q_req,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic signed [asob_pkg::BASE_W-1:0] out_sample,
  output logic                              out_saturated
);

  localparam int PB = asob_pkg::PHASE_BITS;
  localparam int IW = asob_pkg::IDX_W;
  localparam int AW = asob_pkg::AMP_W;
  localparam int TB = asob_pkg::SINE_TABLE_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [IW:0] rd_cnt_r, rd_cnt_nxt;      // next address to read
  logic [IW:0] count_r;
  logic        v1_r, v2_r;                // pipeline valids
  logic [IW-1:0] a1_r;
  logic [asob_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [asob_pkg::BASE_W-1:0] res_r;
  logic        sat_r;

  // parameter memory {inc, amp, offset}, running phase memory
  logic                        pm_we, ph_we;
  logic [IW-1:0]               pm_wa, ph_wa;
  logic [asob_pkg::RAM_W-1:0]  pm_wd, pm_rd;
  logic [PB-1:0]               ph_wd, ph_rd;
  logic [IW-1:0]               rd_addr;
  logic [IW:0]                 clr_r;

  // stage 2 registers
  logic signed [15:0] sine2_r;
  logic signed [AW-1:0] amp2_r;
  logic               act2_r;

  logic [PB-1:0]      inc1, off1, sum1;
  logic signed [AW-1:0] amp1;
  logic               act1;
  logic [TB-1:0]      tidx;
  logic [TB-3:0]      q_pos;
  logic [TB-2:0]      q_k;
  logic [15:0]        q_mag;
  logic signed [15:0] sine1;
  logic signed [31:0] prod;
  logic               clearing;

  assign clearing = (state_r == S_CLEAR);
  assign rd_addr  = rd_cnt_r[IW-1:0];
  assign {inc1, amp1, off1} = pm_rd;
  assign sum1 = ph_rd + off1;
  assign act1 = v1_r && !inc1[PB-1] && (amp1 != '0);
  assign tidx = sum1[PB-1 -: TB];

  // quarter-wave lookup: mirror odd quarters, negate the second half turn
  assign q_pos = tidx[TB-3:0];
  assign q_k   = tidx[TB-2] ? (TB-1)'(asob_pkg::QLEN) - {1'b0, q_pos} : {1'b0, q_pos};
  assign q_mag = q_k[TB-2] ? asob_pkg::SINE_PEAK
                           : asob_pkg::QUARTER_ROM[{q_k[TB-3:0], 4'd0} +: 16];
  assign sine1 = tidx[TB-1] ? -$signed(q_mag) : $signed(q_mag);

  asob_ram #(.WIDTH(asob_pkg::RAM_W), .DEPTH(asob_pkg::PARTIALS)) u_par (
    .clk(clk), .wr_en(pm_we), .wr_addr(pm_wa), .wr_data(pm_wd),
    .rd_addr(rd_addr), .rd_data(pm_rd));

  asob_ram #(.WIDTH(PB), .DEPTH(asob_pkg::PARTIALS)) u_phase (
    .clk(clk), .wr_en(ph_we), .wr_addr(ph_wa), .wr_data(ph_wd),
    .rd_addr(rd_addr), .rd_data(ph_rd));

  always_comb begin
    pm_we = 1'b0;
    pm_wa = q_req.partial_index;
    pm_wd = {q_req.phase_increment, q_req.amplitude, q_req.phase_offset};
    ph_we = 1'b0;
    ph_wa = q_req.partial_index;
    ph_wd = '0;
    q_pop = 1'b0;
    if (clearing) begin
      pm_we = 1'b1; pm_wa = clr_r[IW-1:0]; pm_wd = '0;
      ph_we = 1'b1; ph_wa = clr_r[IW-1:0];
    end else if (state_r == S_IDLE && q_valid && q_req.op == asob_pkg::OP_LOAD) begin
      pm_we = 1'b1;
      ph_we = 1'b1;
      q_pop = 1'b1;
    end else if (act1) begin
      ph_we = 1'b1;
      ph_wa = a1_r;
      ph_wd = ph_rd + inc1;
    end
    if (state_r == S_OUT && out_tready) q_pop = 1'b1;
  end

  assign prod = amp2_r * sine2_r;

  always_comb begin
    acc_nxt = acc_r;
    if (v2_r && act2_r) acc_nxt = acc_r + {{32{prod[31]}}, prod};
  end

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (IW+1)'(asob_pkg::PARTIALS - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        rd_cnt_nxt = '0;
        if (q_valid && q_req.op == asob_pkg::OP_TICK) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (rd_cnt_r < count_r) rd_cnt_nxt = rd_cnt_r + 1'b1;
        else if (!v1_r && !v2_r) state_nxt = S_ROUND;
      end
      S_ROUND: state_nxt = S_OUT;
      S_OUT:   if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [asob_pkg::ACC_W-1:0] rnd;
  logic signed [asob_pkg::ACC_W-16:0] shq;
  assign rnd = acc_r + 64'd16384;
  assign shq = rnd[asob_pkg::ACC_W-1:15];

  always_ff @(posedge clk) begin
    a1_r    <= rd_addr;
    sine2_r <= sine1;
    amp2_r  <= amp1;
    act2_r  <= act1;
    if (state_r == S_IDLE)
      acc_r <= {{17{q_req.base_sample[31]}}, q_req.base_sample, 15'd0};
    else
      acc_r <= acc_nxt;
    if (state_r == S_ROUND) begin
      if (shq > 49'sh0_7FFF_FFFF) begin
        res_r <= 32'sh7FFF_FFFF; sat_r <= 1'b1;
      end else if (shq < -49'sh0_8000_0000) begin
        res_r <= 32'sh8000_0000; sat_r <= 1'b1;
      end else begin
        res_r <= shq[31:0]; sat_r <= 1'b0;
      end
    end
    if (state_r == S_IDLE)
      count_r <= (partials_in_use > asob_pkg::PARTIALS) ? (IW+1)'(asob_pkg::PARTIALS)
                                                        : partials_in_use;
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      rd_cnt_r <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      if (clearing) clr_r <= clr_r + 1'b1;
      v1_r <= (state_r == S_SWEEP) && (rd_cnt_r < count_r);
      v2_r <= v1_r;
    end
  end

  assign out_tvalid    = (state_r == S_OUT);
  assign out_sample    = res_r;
  assign out_saturated = sat_r;

endmodule

/* rtl/core/additive_sine_oscillator_bank.sv */
// ----------------------------------------------------------------------------
// additive_sine_oscillator_bank: additive synthesis bank of 512 sine partials
// Load requests program one partial; tick requests produce one summed sample.
// ----------------------------------------------------------------------------
// After reset the engine clears both partial memories, one entry a cycle,
// and starts no request in that time; the queue still takes up to two
// requests meanwhile. A load request is done in the idle state, so loads
// can follow each other with no gap. A tick request sweeps the first
// partials_in_use entries (capped at 512) through the single read port of the
// partial memories, one entry a cycle. The engine then rounds and saturates
// the sum, raises out_tvalid and takes no new request until out_tready
// accepts the sample. The tick under way keeps its queue slot until its
// sample is taken, so one further request can wait behind it.
module additive_sine_oscillator_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,     // partials_in_use
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,      // op
  // [8:0] partial_index, [32:9] phase_increment, [48:33] amplitude,
  // [72:49] phase_offset, [104:73] base_sample, [111:105] zero
  input  logic [111:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,     // saturated
  output logic [31:0] out_tdata      // [31:0] sample
);

  logic [9:0] piu_r;
  asob_pkg::req_t in_req, q_req;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) piu_r <= 10'd512;
    else if (cfg_we) piu_r <= cfg_wdata;
  end

  assign in_req.op              = in_tuser;
  assign in_req.partial_index   = in_tdata[8:0];
  assign in_req.phase_increment = in_tdata[32:9];
  assign in_req.amplitude       = in_tdata[48:33];
  assign in_req.phase_offset    = in_tdata[72:49];
  assign in_req.base_sample     = in_tdata[104:73];

  asob_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid),
    .in_tready(in_tready), .in_req(in_req), .q_valid(q_valid), .q_pop(q_pop),
    .q_req(q_req));

  asob_engine u_engine (
    .clk(clk), .rst_n(rst_n), .partials_in_use(piu_r), .q_valid(q_valid),
    .q_pop(q_pop), .q_req(q_req), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_sample(out_tdata), .out_saturated(out_tuser));

endmodule
